// ===== src/tts_pkg.sv =====
// Shared types and constants for the transposition table probe/store block.
// Used by tts_table and transposition_table_probe_store; depends on nothing.
package tts_pkg;

    localparam int unsigned INDEX_BITS = 16;
    localparam int unsigned SLOT_COUNT = 1 << INDEX_BITS;

    localparam logic [14:0] MATE_RESET  = 15'd32000;
    localparam int          MATE_WINDOW = 1000;

    localparam logic ACT_PROBE = 1'b0;
    localparam logic ACT_STORE = 1'b1;

    localparam logic [1:0] KIND_EXACT = 2'd0;
    localparam logic [1:0] KIND_LOWER = 2'd1;
    localparam logic [1:0] KIND_UPPER = 2'd2;

    localparam logic ADDR_MATE = 1'b0;

    typedef logic [INDEX_BITS-1:0] t_index;

    typedef struct packed {
        logic [63:0]        key;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic signed [7:0]  depth;
        logic [1:0]         kind;
    } t_entry;

    typedef struct packed {
        logic   en;
        t_index idx;
    } t_rd_req;

    typedef struct packed {
        logic   en;
        t_index idx;
        t_entry entry;
    } t_wr_req;

endpackage

// ===== src/transposition_table_probe_store.sv =====
// Top level of the transposition table: APB register, request pipeline, score
// conversion and cutoff test. Depends on tts_pkg and tts_table.
// The result strobe o_done is high for one cycle; an accepted item passes
// through r_a_vld and r_b_vld into r_done. Throughput: one transaction per cycle
// while busy is low, set by one read and one write of the slot memory per cycle.
// After reset, busy stays high while the memory is swept to zero; the mate limit
// resets to 32000. The receiver cannot stall, so results are never held.
module transposition_table_probe_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_action,
    input  logic [63:0]         i_key,
    input  logic [15:0]         i_move_in,
    input  logic signed [15:0]  i_score_in,
    input  logic signed [7:0]   i_depth_in,
    input  logic [1:0]          i_kind_in,
    input  logic [7:0]          i_ply,
    input  logic signed [31:0]  i_alpha,
    input  logic signed [31:0]  i_beta,
    output logic                o_done,
    output logic                o_hit,
    output logic [15:0]         o_move_out,
    output logic signed [15:0]  o_score_out,
    output logic signed [7:0]   o_depth_out,
    output logic [1:0]          o_kind_out,
    output logic                o_cutoff,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import tts_pkg::*;

    logic               accept;
    logic               cfg_wr;
    logic [14:0]        r_mate;
    logic signed [16:0] mate_hi;
    logic signed [16:0] mate_lo;
    logic               tbl_busy;
    t_rd_req            rd_req;
    t_wr_req            wr_req;
    t_entry             rd_data;
    logic signed [15:0] store_score;

    // Stage A: memory read in flight.
    logic               r_a_vld;
    logic               r_a_probe;
    logic [63:0]        r_a_key;
    logic signed [7:0]  r_a_depth;
    logic [7:0]         r_a_ply;
    logic signed [31:0] r_a_alpha;
    logic signed [31:0] r_a_beta;
    logic               a_hit;
    logic signed [15:0] a_score;

    // Stage B: converted entry, cutoff test pending.
    logic               r_b_vld;
    logic               r_b_hit;
    logic [15:0]        r_b_move;
    logic signed [15:0] r_b_score;
    logic signed [7:0]  r_b_depth;
    logic [1:0]         r_b_kind;
    logic               r_b_deep;
    logic signed [31:0] r_b_alpha;
    logic signed [31:0] r_b_beta;
    logic               b_cut;

    logic               r_done;
    logic               r_hit;
    logic [15:0]        r_move;
    logic signed [15:0] r_score;
    logic signed [7:0]  r_depth;
    logic [1:0]         r_kind;
    logic               r_cutoff;

    assign busy   = tbl_busy;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate <= MATE_RESET;
        end else if (cfg_wr && paddr[2] == ADDR_MATE) begin
            r_mate <= pwdata[14:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_MATE) begin
            prdata = {17'd0, r_mate};
        end
    end

    assign mate_hi = $signed({2'b00, r_mate}) - 17'sd1000;
    assign mate_lo = 17'sd1000 - $signed({2'b00, r_mate});

    // Scores near mate are stored relative to the current node and brought back
    // relative to the root on a probe; both wrap at 16 bits.
    always_comb begin
        store_score = i_score_in;
        if ($signed({i_score_in[15], i_score_in}) > mate_hi) begin
            store_score = i_score_in + $signed({8'd0, i_ply});
        end else if ($signed({i_score_in[15], i_score_in}) < mate_lo) begin
            store_score = i_score_in - $signed({8'd0, i_ply});
        end
    end

    assign rd_req.en  = accept;
    assign rd_req.idx = i_key[INDEX_BITS-1:0];

    // A store writes at its accepting edge, so the next item's read already
    // sees it and no forwarding path is needed.
    assign wr_req.en          = accept && i_action == ACT_STORE;
    assign wr_req.idx         = i_key[INDEX_BITS-1:0];
    assign wr_req.entry.key   = i_key;
    assign wr_req.entry.move  = i_move_in;
    assign wr_req.entry.score = store_score;
    assign wr_req.entry.depth = i_depth_in;
    assign wr_req.entry.kind  = i_kind_in;

    tts_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd_req),
        .i_wr      (wr_req),
        .o_rd_data (rd_data),
        .o_busy    (tbl_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_probe <= i_action == ACT_PROBE;
            r_a_key   <= i_key;
            r_a_depth <= i_depth_in;
            r_a_ply   <= i_ply;
            r_a_alpha <= i_alpha;
            r_a_beta  <= i_beta;
        end
    end

    assign a_hit = r_a_probe && rd_data.key == r_a_key;

    always_comb begin
        a_score = rd_data.score;
        if ($signed({rd_data.score[15], rd_data.score}) > mate_hi) begin
            a_score = rd_data.score - $signed({8'd0, r_a_ply});
        end else if ($signed({rd_data.score[15], rd_data.score}) < mate_lo) begin
            a_score = rd_data.score + $signed({8'd0, r_a_ply});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_hit   <= a_hit;
        r_b_move  <= rd_data.move;
        r_b_score <= a_score;
        r_b_depth <= rd_data.depth;
        r_b_kind  <= rd_data.kind;
        r_b_deep  <= r_a_depth <= rd_data.depth;
        r_b_alpha <= r_a_alpha;
        r_b_beta  <= r_a_beta;
    end

    always_comb begin
        b_cut = 1'b0;
        if (r_b_hit && r_b_deep) begin
            case (r_b_kind)
                KIND_EXACT: b_cut = 1'b1;
                KIND_LOWER: b_cut = $signed({{16{r_b_score[15]}}, r_b_score}) >= r_b_beta;
                KIND_UPPER: b_cut = $signed({{16{r_b_score[15]}}, r_b_score}) <= r_b_alpha;
                default:    b_cut = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_b_vld;
        end
    end

    // Misses and stores report all-zero fields.
    always_ff @(posedge i_clk) begin
        r_hit    <= r_b_hit;
        r_move   <= r_b_hit ? r_b_move : 16'd0;
        r_score  <= r_b_hit ? r_b_score : 16'sd0;
        r_depth  <= r_b_hit ? r_b_depth : 8'sd0;
        r_kind   <= r_b_hit ? r_b_kind : 2'd0;
        r_cutoff <= b_cut;
    end

    assign o_done      = r_done;
    assign o_hit       = r_hit;
    assign o_move_out  = r_move;
    assign o_score_out = r_score;
    assign o_depth_out = r_depth;
    assign o_kind_out  = r_kind;
    assign o_cutoff    = r_cutoff;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 3))
        else $error("result without an accepted transaction");

    a_store_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_STORE) |-> ##3 (!o_hit && !o_cutoff))
        else $error("store transaction reported a hit or cutoff");

    a_cut_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_hit |-> !o_cutoff && o_move_out == 16'd0)
        else $error("miss reported entry data");

endmodule

// ===== src/tts_table.sv =====
// Slot memory of the transposition table with its post-reset clearing sweep.
// Depends on tts_pkg for the entry and request types.
module tts_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tts_pkg::t_rd_req i_rd,
    input  tts_pkg::t_wr_req i_wr,
    output tts_pkg::t_entry  o_rd_data,
    output logic             o_busy
);
    import tts_pkg::*;

    t_entry r_mem [SLOT_COUNT];
    t_entry r_rd_data;
    logic   r_clearing;
    t_index r_clr_idx;

    // The sweep zeroes one slot per cycle; the requester is held off meanwhile.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {INDEX_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.idx];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clearing && r_clr_idx == {INDEX_BITS{1'b1}}) |=> !r_clearing)
        else $error("clearing sweep did not finish after the last slot");

    a_clear_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clearing && r_clr_idx != {INDEX_BITS{1'b1}}) |=> r_clearing)
        else $error("clearing sweep stopped early");

    a_no_write_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_wr.en)
        else $error("slot written while the clearing sweep runs");

endmodule
